### design/typed_handle_table_defines.svh
// ----------------------------------------------------------------------------
// typed_handle_table_defines
// Assertion macros shared by the typed handle table RTL.
// ----------------------------------------------------------------------------
`ifndef TYPED_HANDLE_TABLE_DEFINES_SVH
`define TYPED_HANDLE_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
`define THT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("typed_handle_table: assertion failed");
`define THT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("typed_handle_table: assertion failed");
`else
`define THT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define THT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### design/tht_pkg.sv
// ----------------------------------------------------------------------------
// tht_pkg
// Codes and shared types of the typed handle table.
// ----------------------------------------------------------------------------
package tht_pkg;

	localparam logic [1:0] ACT_ALLOC  = 2'd0;
	localparam logic [1:0] ACT_FREE   = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_RANGE   = 3'd1;
	localparam logic [2:0] ST_TYPE    = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_CORRUPT = 3'd4;

	localparam logic [3:0] TAG_FREE   = 4'd0;

	localparam int HANDLE_W  = 8;
	localparam int VALUE_W   = 32;
	localparam int TAG_W     = 4;
	localparam int LINK_BIT  = 8;
	localparam int MAX_SLOTS = 256;

	typedef struct packed {
		logic capture;
		logic commit;
	} tht_cmd_t;

endpackage

### design/tht_req_if.sv
// ----------------------------------------------------------------------------
// tht_req_if
// Request channel: action, handle, object value and type tag.
// ----------------------------------------------------------------------------
interface tht_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [7:0]  handle;
	logic [31:0] object_value;
	logic [3:0]  type_tag;

	modport source (output valid, action, handle, object_value, type_tag, input ready);
	modport sink (input valid, action, handle, object_value, type_tag, output ready);
endinterface

### design/tht_rsp_if.sv
// ----------------------------------------------------------------------------
// tht_rsp_if
// Response channel: status, result handle and result value.
// ----------------------------------------------------------------------------
interface tht_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  result_handle;
	logic [31:0] result_value;

	modport source (output valid, status, result_handle, result_value, input ready);
	modport sink (input valid, status, result_handle, result_value, output ready);
endinterface

### design/typed_handle_table.sv
// ----------------------------------------------------------------------------
// typed_handle_table
// Fixed-capacity typed handle table with a LIFO free list threaded through
// freed entries.
// ----------------------------------------------------------------------------
//  channel | modport | payload
//  req     | sink    | action, handle, object_value, type_tag
//  rsp     | source  | status, result_handle, result_value
//
// The accept edge starts the entry-store read and enters S_READ; the commit
// edge writes the entry back and loads the response register. A new item is
// accepted only once the previous one has committed, after the registered
// read then write of the entry store. Reset clears the slot counter and
// free-list head; the entry store needs no clearing. A stalled response
// holds S_READ until the response register frees up.
module typed_handle_table import tht_pkg::*; #(
	parameter int CAPACITY = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	tht_req_if.sink    req,
	tht_rsp_if.source  rsp
);
	localparam int SLOTS = (CAPACITY > MAX_SLOTS) ? MAX_SLOTS : CAPACITY;

	tht_cmd_t cmd;

	tht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.cmd      (cmd)
	);

	tht_dp #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.action       (req.action),
		.handle       (req.handle),
		.object_value (req.object_value),
		.type_tag     (req.type_tag),
		.status       (rsp.status),
		.result_handle(rsp.result_handle),
		.result_value (rsp.result_value)
	);
endmodule

### design/tht_ram.sv
// ----------------------------------------------------------------------------
// tht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tht_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

### design/tht_ctrl.sv
// ----------------------------------------------------------------------------
// tht_ctrl
// Request sequencer: accept, read the entry, commit into the response slot.
// ----------------------------------------------------------------------------
`include "typed_handle_table_defines.svh"

module tht_ctrl import tht_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output tht_cmd_t cmd
);
	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign in_ready    = (state_q == S_IDLE);
	assign slot_free   = !out_valid_q || out_ready;
	assign cmd.capture = in_valid && in_ready;
	assign cmd.commit  = (state_q == S_READ) && slot_free;
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.capture) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (cmd.commit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`THT_ASSERT_NEXT(a_capture_reads, clk, arst_n, cmd.capture, state_q == S_READ)
	`THT_ASSERT_NEXT(a_commit_shows, clk, arst_n, cmd.commit, out_valid_q)
	`THT_ASSERT_IMPL(a_commit_slot, clk, arst_n, cmd.commit, !out_valid_q || out_ready)
	`THT_ASSERT_IMPL(a_no_overlap, clk, arst_n, cmd.capture, !cmd.commit)
endmodule

### design/tht_dp.sv
// ----------------------------------------------------------------------------
// tht_dp
// Entry store, free-list head, slot counter and response register.
// ----------------------------------------------------------------------------
module tht_dp import tht_pkg::*; #(
	parameter int SLOTS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  tht_cmd_t    cmd,
	input  logic [1:0]  action,
	input  logic [7:0]  handle,
	input  logic [31:0] object_value,
	input  logic [3:0]  type_tag,
	output logic [2:0]  status,
	output logic [7:0]  result_handle,
	output logic [31:0] result_value
);
	localparam int AW = $clog2(SLOTS);
	localparam int UW = $clog2(SLOTS + 1);
	localparam int EW = TAG_W + VALUE_W;

	logic [1:0]          act_q;
	logic [7:0]          handle_q;
	logic [31:0]         value_q;
	logic [3:0]          tag_q;
	logic [UW-1:0]       used_q;
	logic [AW-1:0]       head_q;
	logic                head_vld_q;
	logic [2:0]          status_q;
	logic [7:0]          rhandle_q;
	logic [31:0]         rvalue_q;

	logic [AW-1:0]       rd_addr;
	logic [EW-1:0]       rd_data;
	logic [3:0]          rd_type;
	logic [31:0]         rd_value;
	logic                wr_do;
	logic [AW-1:0]       wr_addr;
	logic [EW-1:0]       wr_data;
	logic [2:0]          status_d;
	logic [7:0]          rhandle_d;
	logic [31:0]         rvalue_d;
	logic                do_pop;
	logic                do_push;
	logic                do_inc;

	assign rd_addr  = (action == ACT_ALLOC) ? head_q : handle[AW-1:0];
	assign rd_type  = rd_data[EW-1 -: TAG_W];
	assign rd_value = rd_data[VALUE_W-1:0];

	tht_ram #(
		.WIDTH(EW),
		.DEPTH(SLOTS)
	) u_ram (
		.clk    (clk),
		.wr_en  (cmd.commit && wr_do),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (cmd.capture),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		status_d  = ST_OK;
		rhandle_d = handle_q;
		rvalue_d  = '0;
		wr_do     = 1'b0;
		wr_addr   = handle_q[AW-1:0];
		wr_data   = {tag_q, value_q};
		do_pop    = 1'b0;
		do_push   = 1'b0;
		do_inc    = 1'b0;
		if (tag_q == TAG_FREE) begin
			status_d = ST_TYPE;
		end else if (act_q == ACT_ALLOC) begin
			if (head_vld_q) begin
				if (rd_type != TAG_FREE) begin
					status_d = ST_CORRUPT;
				end else begin
					wr_do     = 1'b1;
					wr_addr   = head_q;
					rhandle_d = 8'(head_q);
					do_pop    = 1'b1;
				end
			end else if (used_q >= UW'(SLOTS)) begin
				status_d = ST_FULL;
			end else begin
				wr_do     = 1'b1;
				wr_addr   = used_q[AW-1:0];
				rhandle_d = 8'(used_q);
				do_inc    = 1'b1;
			end
		end else if ({1'b0, handle_q} >= 9'(used_q)) begin
			status_d = ST_RANGE;
		end else if (rd_type != tag_q) begin
			status_d = ST_TYPE;
		end else begin
			rvalue_d = rd_value;
			if (act_q == ACT_FREE) begin
				wr_do   = 1'b1;
				wr_data = {TAG_FREE, 23'd0, head_vld_q, 8'(head_q)};
				do_push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q    <= action;
			handle_q <= handle;
			value_q  <= object_value;
			tag_q    <= type_tag;
		end
		if (cmd.commit) begin
			status_q  <= status_d;
			rhandle_q <= rhandle_d;
			rvalue_q  <= rvalue_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			head_q     <= '0;
			head_vld_q <= 1'b0;
		end else if (cmd.commit) begin
			if (do_inc) begin
				used_q <= used_q + UW'(1);
			end
			if (do_pop) begin
				head_q     <= rd_value[AW-1:0];
				head_vld_q <= rd_value[LINK_BIT];
			end else if (do_push) begin
				head_q     <= handle_q[AW-1:0];
				head_vld_q <= 1'b1;
			end
		end
	end

	assign status        = status_q;
	assign result_handle = rhandle_q;
	assign result_value  = rvalue_q;
endmodule
